>>> sv/lfps_pkg.sv
// Shared types, constants and the microcode ROM of the line-follow PID steering core.
// No dependencies; compiled first.
package lfps_pkg;

  localparam int SENSOR_W = 10;
  localparam int DUTY_W   = 7;
  localparam int GAIN_W   = 4;
  localparam int CODE_W   = 2;
  localparam int STEP_W   = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [11:0] FULL_SCALE = 12'd1000;

  // special_action codes
  localparam logic [CODE_W-1:0] ACT_NORMAL = 2'd0;
  localparam logic [CODE_W-1:0] ACT_STOP   = 2'd1;
  localparam logic [CODE_W-1:0] ACT_PIVOT  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_BASE      = 3'd3;
  localparam logic [2:0] REG_FLOOR     = 3'd4;
  localparam logic [2:0] REG_CEILING   = 3'd5;
  localparam logic [2:0] REG_INT_LIMIT = 3'd6;

  // datapath operations
  localparam logic [2:0] OP_NOP  = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_DIV  = 3'd2;
  localparam logic [2:0] OP_ERR  = 3'd3;
  localparam logic [2:0] OP_ERRZ = 3'd4;
  localparam logic [2:0] OP_INT  = 3'd5;
  localparam logic [2:0] OP_MUL  = 3'd6;
  localparam logic [2:0] OP_DUTY = 3'd7;

  // sequencer conditions
  localparam logic [2:0] C_NEXT    = 3'd0;
  localparam logic [2:0] C_JUMP    = 3'd1;
  localparam logic [2:0] C_SUMZ    = 3'd2;
  localparam logic [2:0] C_WAITIN  = 3'd3;
  localparam logic [2:0] C_WAITOUT = 3'd4;

  // multiplier operand select
  localparam logic [1:0] MS_P = 2'd0;
  localparam logic [1:0] MS_I = 2'd1;
  localparam logic [1:0] MS_D = 2'd2;

  typedef struct packed {
    logic [2:0]        op;
    logic [1:0]        sh;    // divisor shift for OP_DIV
    logic [1:0]        msel;  // multiplier operand for OP_MUL
    logic              clr;   // start a fresh accumulation
    logic [2:0]        cond;
    logic [STEP_W-1:0] tgt;
  } ucw_t;

  function automatic ucw_t ucode(input logic [STEP_W-1:0] s);
    ucw_t w;
    w = '{op: OP_NOP, sh: 2'd0, msel: MS_P, clr: 1'b0, cond: C_JUMP, tgt: 4'd0};
    case (s)
      4'd0:  w = '{op: OP_LOAD, sh: 2'd0, msel: MS_P, clr: 1'b0, cond: C_WAITIN,  tgt: 4'd0};
      4'd1:  w = '{op: OP_DIV,  sh: 2'd2, msel: MS_P, clr: 1'b0, cond: C_SUMZ,    tgt: 4'd5};
      4'd2:  w = '{op: OP_DIV,  sh: 2'd1, msel: MS_P, clr: 1'b0, cond: C_NEXT,    tgt: 4'd0};
      4'd3:  w = '{op: OP_DIV,  sh: 2'd0, msel: MS_P, clr: 1'b0, cond: C_NEXT,    tgt: 4'd0};
      4'd4:  w = '{op: OP_ERR,  sh: 2'd0, msel: MS_P, clr: 1'b0, cond: C_JUMP,    tgt: 4'd6};
      4'd5:  w = '{op: OP_ERRZ, sh: 2'd0, msel: MS_P, clr: 1'b0, cond: C_NEXT,    tgt: 4'd0};
      4'd6:  w = '{op: OP_INT,  sh: 2'd0, msel: MS_P, clr: 1'b0, cond: C_NEXT,    tgt: 4'd0};
      4'd7:  w = '{op: OP_MUL,  sh: 2'd0, msel: MS_P, clr: 1'b1, cond: C_NEXT,    tgt: 4'd0};
      4'd8:  w = '{op: OP_MUL,  sh: 2'd0, msel: MS_I, clr: 1'b0, cond: C_NEXT,    tgt: 4'd0};
      4'd9:  w = '{op: OP_MUL,  sh: 2'd0, msel: MS_D, clr: 1'b0, cond: C_NEXT,    tgt: 4'd0};
      4'd10: w = '{op: OP_DUTY, sh: 2'd0, msel: MS_P, clr: 1'b0, cond: C_WAITOUT, tgt: 4'd0};
      default: ;
    endcase
    return w;
  endfunction

endpackage

>>> sv/lfps_in_if.sv
// Input channel: four sensor readings with valid/ready.
// Depends on lfps_pkg.
interface lfps_in_if import lfps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] sensor_outer_left;
  logic [SENSOR_W-1:0] sensor_inner_left;
  logic [SENSOR_W-1:0] sensor_inner_right;
  logic [SENSOR_W-1:0] sensor_outer_right;

  modport source (output valid, sensor_outer_left, sensor_inner_left,
                  sensor_inner_right, sensor_outer_right, input ready);
  modport sink   (input valid, sensor_outer_left, sensor_inner_left,
                  sensor_inner_right, sensor_outer_right, output ready);
endinterface

>>> sv/lfps_out_if.sv
// Result channel: motor duties and special action code with valid/ready.
// Depends on lfps_pkg.
interface lfps_out_if import lfps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] left_duty;
  logic [DUTY_W-1:0] right_duty;
  logic [CODE_W-1:0] special_action;

  modport source (output valid, left_duty, right_duty, special_action, input ready);
  modport sink   (input valid, left_duty, right_duty, special_action, output ready);
endinterface

>>> sv/line_follow_pid_steering_core.sv
// Line-follow PID steering core: microcoded sequencer over a small shared datapath.
// Depends on lfps_pkg, lfps_in_if, lfps_out_if.
//
//  channel   direction  handshake          payload
//  in_ch     sink       valid/ready        four 10-bit sensor readings
//  out_ch    source     valid/ready        left_duty, right_duty, special_action
//  cfg (APB) slave      psel/penable       7 registers at 4*i, pready tied high
//
// An item is taken in the idle/load step and then passes through three restoring-divide
// steps (only the first when all readings are zero), error scaling, integral update and
// three passes through the one 5x8 multiplier, then the duty step, before the next ready.
// The micro-step counter sequences these steps. Reset is synchronous, active low, and
// clears the registers to their defaults and the PID state to zero; no clearing pass.
// A stalled result holds in the output register; the duty step waits only if it is still full.
module line_follow_pid_steering_core import lfps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  lfps_in_if.sink           in_ch,
  lfps_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // configuration
  logic [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [DUTY_W-1:0] base_r, floor_r, ceil_r, lim_r;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= 4'd5;
      gain_i_r <= 4'd0;
      gain_d_r <= 4'd2;
      base_r   <= 7'd40;
      floor_r  <= 7'd30;
      ceil_r   <= 7'd50;
      lim_r    <= 7'd30;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_P:    gain_p_r <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:    gain_i_r <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:    gain_d_r <= pwdata[GAIN_W-1:0];
        REG_BASE:      base_r   <= pwdata[DUTY_W-1:0];
        REG_FLOOR:     floor_r  <= pwdata[DUTY_W-1:0];
        REG_CEILING:   ceil_r   <= pwdata[DUTY_W-1:0];
        REG_INT_LIMIT: lim_r    <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_GAIN_P:    prdata = {{(DATA_W-GAIN_W){1'b0}}, gain_p_r};
      REG_GAIN_I:    prdata = {{(DATA_W-GAIN_W){1'b0}}, gain_i_r};
      REG_GAIN_D:    prdata = {{(DATA_W-GAIN_W){1'b0}}, gain_d_r};
      REG_BASE:      prdata = {{(DATA_W-DUTY_W){1'b0}}, base_r};
      REG_FLOOR:     prdata = {{(DATA_W-DUTY_W){1'b0}}, floor_r};
      REG_CEILING:   prdata = {{(DATA_W-DUTY_W){1'b0}}, ceil_r};
      REG_INT_LIMIT: prdata = {{(DATA_W-DUTY_W){1'b0}}, lim_r};
      default:       prdata = '0;
    endcase
  end

  // sequencer
  logic [STEP_W-1:0] step_r, step_nxt;
  ucw_t              uc;
  logic              in_acc, out_free, sum_zero, exec;

  logic [11:0]        sum_r;
  logic [12:0]        rem_r;
  logic               neg_r;
  logic [2:0]         q_r;
  logic [CODE_W-1:0]  code_r;
  logic signed [6:0]  err_r;
  logic signed [6:0]  last_r;
  logic signed [7:0]  integ_r;
  logic signed [7:0]  diff_r;
  logic signed [13:0] acc_r;

  logic              out_valid_r;
  logic [DUTY_W-1:0] left_r, right_r;
  logic [CODE_W-1:0] act_r;

  assign uc       = ucode(step_r);
  assign in_ch.ready = (step_r == 4'd0);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign sum_zero = (sum_r == 12'd0);

  always_comb begin
    exec = 1'b1;
    if (uc.cond == C_WAITIN)  exec = in_acc;
    if (uc.cond == C_WAITOUT) exec = out_free;
  end

  always_comb begin
    case (uc.cond)
      C_NEXT:    step_nxt = step_r + 4'd1;
      C_JUMP:    step_nxt = uc.tgt;
      C_SUMZ:    step_nxt = sum_zero ? uc.tgt : step_r + 4'd1;
      C_WAITIN:  step_nxt = in_acc ? step_r + 4'd1 : step_r;
      C_WAITOUT: step_nxt = out_free ? uc.tgt : step_r;
      default:   step_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= '0;
    else        step_r <= step_nxt;
  end

  // datapath combinational pieces
  logic [11:0]        ld_sum;
  logic signed [13:0] ld_w;
  logic [12:0]        ld_abs;
  logic               ld_stop, ld_pivot;
  logic [13:0]        dv_cand;
  logic               dv_ge;
  logic [5:0]         err_mag;
  logic signed [8:0]  int_sum, int_lim;
  logic signed [7:0]  int_nxt;
  logic signed [7:0]  mul_b;
  logic [GAIN_W-1:0]  mul_g;
  logic signed [12:0] prod;
  logic signed [14:0] left_v, right_v, base_s, floor_s, ceil_s;
  logic [DUTY_W-1:0]  left_c, right_c;

  always_comb begin
    ld_sum = {2'b00, in_ch.sensor_outer_left} + {2'b00, in_ch.sensor_inner_left}
           + {2'b00, in_ch.sensor_inner_right} + {2'b00, in_ch.sensor_outer_right};
    ld_w = $signed({2'b00, in_ch.sensor_outer_right, 2'b00})
         + $signed({4'b0000, in_ch.sensor_inner_right})
         - $signed({2'b00, in_ch.sensor_outer_left, 2'b00})
         - $signed({4'b0000, in_ch.sensor_inner_left});
    ld_abs   = ld_w[13] ? 13'(-ld_w) : ld_w[12:0];
    ld_stop  = (ld_sum == 12'd0);
    ld_pivot = ({2'b00, in_ch.sensor_outer_left} == FULL_SCALE)
            && ({2'b00, in_ch.sensor_inner_left} == FULL_SCALE)
            && ({2'b00, in_ch.sensor_inner_right} == FULL_SCALE);
  end

  assign dv_cand = {2'b00, sum_r} << uc.sh;
  assign dv_ge   = ({1'b0, rem_r} >= dv_cand);
  // q * 10 = q*8 + q*2
  assign err_mag = {q_r, 3'b000} + {2'b00, q_r, 1'b0};

  always_comb begin
    int_sum = 9'(integ_r) + 9'(err_r);
    int_lim = $signed({2'b00, lim_r});
    if (int_sum > int_lim)       int_nxt = 8'(int_lim);
    else if (int_sum < -int_lim) int_nxt = 8'(-int_lim);
    else                         int_nxt = int_sum[7:0];
  end

  always_comb begin
    case (uc.msel)
      MS_P:    begin mul_g = gain_p_r; mul_b = 8'(err_r); end
      MS_I:    begin mul_g = gain_i_r; mul_b = integ_r;   end
      MS_D:    begin mul_g = gain_d_r; mul_b = diff_r;    end
      default: begin mul_g = '0;       mul_b = '0;        end
    endcase
  end
  assign prod = $signed({1'b0, mul_g}) * mul_b;

  always_comb begin
    base_s  = $signed({8'd0, base_r});
    floor_s = $signed({8'd0, floor_r});
    ceil_s  = $signed({8'd0, ceil_r});
    left_v  = base_s - 15'(acc_r);
    right_v = base_s + 15'(acc_r);
    // ceiling tested first; if floor > ceiling, above ceiling gives ceiling, else floor
    if (left_v > ceil_s)       left_c = ceil_r;
    else if (left_v < floor_s) left_c = floor_r;
    else                       left_c = left_v[DUTY_W-1:0];
    if (right_v > ceil_s)       right_c = ceil_r;
    else if (right_v < floor_s) right_c = floor_r;
    else                        right_c = right_v[DUTY_W-1:0];
  end

  // working registers: payload, no reset
  always_ff @(posedge clk) begin
    if (exec) begin
      case (uc.op)
        OP_LOAD: begin
          sum_r  <= ld_sum;
          rem_r  <= ld_abs;
          neg_r  <= ld_w[13];
          q_r    <= '0;
          code_r <= ld_stop ? ACT_STOP : (ld_pivot ? ACT_PIVOT : ACT_NORMAL);
        end
        OP_DIV: begin
          if (dv_ge) rem_r <= 13'({1'b0, rem_r} - dv_cand);
          q_r[uc.sh] <= dv_ge;
        end
        OP_ERR:  err_r <= neg_r ? -$signed({1'b0, err_mag}) : $signed({1'b0, err_mag});
        OP_ERRZ: err_r <= '0;
        OP_INT:  diff_r <= 8'(err_r) - 8'(last_r);
        OP_MUL:  acc_r <= (uc.clr ? 14'sd0 : acc_r) + 14'(prod);
        default: ;
      endcase
    end
  end

  // PID state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      integ_r <= '0;
    end else if (exec && uc.op == OP_INT) begin
      last_r  <= err_r;
      integ_r <= int_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec && uc.op == OP_DUTY) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && uc.op == OP_DUTY) begin
      left_r  <= left_c;
      right_r <= right_c;
      act_r   <= code_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.left_duty      = left_r;
  assign out_ch.right_duty     = right_r;
  assign out_ch.special_action = act_r;

endmodule

>>> sv/lfps_checker.sv
// Port-level checker for the steering core, attached by bind.
// Depends on lfps_pkg and line_follow_pid_steering_core.
module lfps_checker import lfps_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DUTY_W-1:0] left_duty,
  input logic [DUTY_W-1:0] right_duty,
  input logic [CODE_W-1:0] special_action
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_duty)
      && $stable(right_duty) && $stable(special_action))
    else $error("stalled result changed");

  // one item at a time: busy right after an input transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> special_action != 2'd3)
    else $error("undefined special action code");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the channels");

endmodule

bind line_follow_pid_steering_core lfps_checker u_lfps_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .left_duty      (out_ch.left_duty),
  .right_duty     (out_ch.right_duty),
  .special_action (out_ch.special_action)
);

>>> tb/sv/tb_line_follow_pid_steering_core.sv
// Testbench for line_follow_pid_steering_core: directed and random sensor transactions,
// APB register setups, a self-computed PID steering prediction and an in-order scoreboard.
// Depends on lfps_pkg, lfps_in_if, lfps_out_if and the core.
`timescale 1ns / 1ps

module tb_line_follow_pid_steering_core;
  import lfps_pkg::*;

  typedef logic [SENSOR_W-1:0] reading_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic [CODE_W-1:0] special_action;
  } duties_t;

  typedef struct {
    int gain_p;
    int gain_i;
    int gain_d;
    int base_duty;
    int duty_floor;
    int duty_ceiling;
    int integral_limit;
  } steer_regs_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lfps_in_if  in_bus ();
  lfps_out_if out_bus ();

  line_follow_pid_steering_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus.sink),
    .out_ch  (out_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // steering mirror: registers and PID state
  steer_regs_t regs_mirror;
  int          err_mirror;
  int          error_accum;

  duties_t pending_duties [$];
  int      fail_count;
  bit      tx_idle;
  bit      rx_idle;
  int      rx_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic duties_t predict_duties(input reading_t a, input reading_t b,
                                             input reading_t c, input reading_t d);
    int ia, ib, ic, id, sum, wsum, err, diff, lim, corr;
    duties_t res;
    ia = int'(a);
    ib = int'(b);
    ic = int'(c);
    id = int'(d);
    sum  = ia + ib + ic + id;
    wsum = -4 * ia - ib + ic + 4 * id;
    err  = (sum != 0) ? (wsum / sum) : 0;
    err  = err * 10;
    diff = err - err_mirror;
    lim  = regs_mirror.integral_limit;
    error_accum = clamp_int(error_accum + err, -lim, lim);
    corr = regs_mirror.gain_p * err + regs_mirror.gain_i * error_accum
         + regs_mirror.gain_d * diff;
    err_mirror = err;
    res.left_duty  = DUTY_W'(clamp_int(regs_mirror.base_duty - corr,
                                       regs_mirror.duty_floor, regs_mirror.duty_ceiling));
    res.right_duty = DUTY_W'(clamp_int(regs_mirror.base_duty + corr,
                                       regs_mirror.duty_floor, regs_mirror.duty_ceiling));
    if (ia == 0 && ib == 0 && ic == 0 && id == 0)
      res.special_action = ACT_STOP;
    else if (ia == FULL_SCALE && ib == FULL_SCALE && ic == FULL_SCALE)
      res.special_action = ACT_PIVOT;
    else
      res.special_action = ACT_NORMAL;
    return res;
  endfunction

  function automatic void report_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Called right after a rising edge; returns with valid still high so a following
  // transaction can go out back to back.
  task automatic send_readings(input reading_t a, input reading_t b,
                               input reading_t c, input reading_t d);
    int idle;
    idle = 0;
    if (tx_idle && $urandom_range(0, 99) < 35) idle = gap_len();
    if (idle > 0) begin
      in_bus.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_bus.valid              <= 1'b1;
    in_bus.sensor_outer_left  <= a;
    in_bus.sensor_inner_left  <= b;
    in_bus.sensor_inner_right <= c;
    in_bus.sensor_outer_right <= d;
    do @(posedge clk); while (!in_bus.ready);
    pending_duties.push_back(predict_duties(a, b, c, d));
  endtask

  // Stop offering and wait for every outstanding result, then let the core settle.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GAIN_P:    regs_mirror.gain_p         = int'(value[3:0]);
      REG_GAIN_I:    regs_mirror.gain_i         = int'(value[3:0]);
      REG_GAIN_D:    regs_mirror.gain_d         = int'(value[3:0]);
      REG_BASE:      regs_mirror.base_duty      = int'(value[6:0]);
      REG_FLOOR:     regs_mirror.duty_floor     = int'(value[6:0]);
      REG_CEILING:   regs_mirror.duty_ceiling   = int'(value[6:0]);
      REG_INT_LIMIT: regs_mirror.integral_limit = int'(value[6:0]);
      default: ;
    endcase
  endtask

  // noisy: junk in the unused upper bits of pwdata
  task automatic set_config(input int gp, input int gi, input int gd, input int base,
                            input int floor_v, input int ceil_v, input int ilim,
                            input bit noisy);
    logic [DATA_W-1:0] junk;
    junk = noisy ? DATA_W'($urandom) : '0;
    write_reg(REG_GAIN_P,    (junk & ~32'hF)  | DATA_W'(gp));
    write_reg(REG_GAIN_I,    (junk & ~32'hF)  | DATA_W'(gi));
    write_reg(REG_GAIN_D,    (junk & ~32'hF)  | DATA_W'(gd));
    write_reg(REG_BASE,      (junk & ~32'h7F) | DATA_W'(base));
    write_reg(REG_FLOOR,     (junk & ~32'h7F) | DATA_W'(floor_v));
    write_reg(REG_CEILING,   (junk & ~32'h7F) | DATA_W'(ceil_v));
    write_reg(REG_INT_LIMIT, (junk & ~32'h7F) | DATA_W'(ilim));
  endtask

  function automatic reading_t random_reading();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 15) return FULL_SCALE[SENSOR_W-1:0];
    if (r < 25) return SENSOR_W'($urandom_range(1000, 1023));
    return SENSOR_W'($urandom_range(0, 1000));
  endfunction

  task automatic random_item();
    int p;
    reading_t s [4];
    p = $urandom_range(0, 99);
    for (int k = 0; k < 4; k++) s[k] = random_reading();
    if (p < 8) begin
      s = '{default: '0};
    end else if (p < 14) begin
      s[0] = FULL_SCALE[SENSOR_W-1:0];
      s[1] = FULL_SCALE[SENSOR_W-1:0];
      s[2] = FULL_SCALE[SENSOR_W-1:0];
    end else if (p < 30) begin
      // line under one sensor, faint elsewhere
      for (int k = 0; k < 4; k++) s[k] = SENSOR_W'($urandom_range(0, 60));
      s[$urandom_range(0, 3)] = SENSOR_W'($urandom_range(500, 1023));
    end
    send_readings(s[0], s[1], s[2], s[3]);
  endtask

  task automatic random_config();
    int base, fl, cl, tmp;
    base = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100);
    fl   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100);
    cl   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100);
    // mostly a sane window
    if (fl > cl && $urandom_range(0, 4) != 0) begin
      tmp = fl;
      fl  = cl;
      cl  = tmp;
    end
    set_config($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
               base, fl, cl, $urandom_range(0, 127), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_reset_defaults();
    send_readings(10'd0, 10'd0, 10'd0, 10'd0);
    send_readings(10'd1000, 10'd1000, 10'd1000, 10'd0);
    send_readings(10'd1000, 10'd1000, 10'd1000, 10'd1023);
    send_readings(10'd1000, 10'd1000, 10'd999, 10'd0);
    send_readings(10'd1000, 10'd0, 10'd0, 10'd0);
    send_readings(10'd0, 10'd0, 10'd0, 10'd1000);
    send_readings(10'd3, 10'd0, 10'd0, 10'd1);      // -8/4 truncates to -2
    send_readings(10'd1, 10'd0, 10'd2, 10'd0);      // -2/3 truncates to 0
    send_readings(10'd0, 10'd1023, 10'd1023, 10'd0);
    send_readings(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    send_readings(10'd0, 10'd0, 10'd1, 10'd0);
    send_readings(10'd682, 10'd341, 10'd170, 10'd85);
    drain();
  endtask

  task automatic test_config_extremes();
    set_config(15, 15, 15, 127, 0, 127, 127, 1'b0);
    send_readings(10'd0, 10'd0, 10'd0, 10'd1023);
    send_readings(10'd0, 10'd0, 10'd0, 10'd1023);
    send_readings(10'd1023, 10'd0, 10'd0, 10'd0);
    send_readings(10'd1023, 10'd0, 10'd0, 10'd0);
    send_readings(10'd0, 10'd0, 10'd0, 10'd0);
    drain();
    set_config(0, 0, 0, 0, 0, 0, 0, 1'b0);
    send_readings(10'd0, 10'd0, 10'd0, 10'd1000);
    send_readings(10'd1000, 10'd1000, 10'd1000, 10'd1000);
    send_readings(10'd0, 10'd0, 10'd0, 10'd0);
    drain();
    // floor above ceiling
    set_config(15, 0, 15, 100, 90, 10, 100, 1'b0);
    send_readings(10'd500, 10'd500, 10'd500, 10'd500);
    send_readings(10'd1000, 10'd0, 10'd0, 10'd0);
    send_readings(10'd0, 10'd0, 10'd0, 10'd1000);
    send_readings(10'd0, 10'd0, 10'd0, 10'd0);
    drain();
  endtask

  // receiver holds off a long stretch while the sender keeps offering
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold = 300;
    repeat (12) random_item();
    drain();
    tx_idle = 1'b1;
  endtask

  task automatic test_random(input int n_items, input bit idle_tx, input bit idle_rx);
    random_config();
    tx_idle = idle_tx;
    rx_idle = idle_rx;
    for (int k = 0; k < n_items; k++) begin
      random_item();
      if ($urandom_range(0, 99) == 0) drain();
    end
    drain();
  endtask

  // result checker and receiver stall control
  initial begin
    duties_t got, want;
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.left_duty, out_bus.right_duty, out_bus.special_action};
        if (pending_duties.size() == 0) begin
          report_fail($sformatf("unexpected result: left %0d right %0d action %0d",
                                got.left_duty, got.right_duty, got.special_action));
        end else begin
          want = pending_duties.pop_front();
          if (got !== want)
            report_fail($sformatf(
              "result mismatch: left %0d/%0d right %0d/%0d action %0d/%0d (exp/act)",
              want.left_duty, got.left_duty, want.right_duty, got.right_duty,
              want.special_action, got.special_action));
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_bus.ready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 99) < 30) begin
        rx_hold = gap_len() - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    fail_count  = 0;
    rx_hold     = 0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    err_mirror  = 0;
    error_accum = 0;
    regs_mirror = '{gain_p: 5, gain_i: 0, gain_d: 2, base_duty: 40, duty_floor: 30,
                    duty_ceiling: 50, integral_limit: 30};
    rst_n                     <= 1'b0;
    psel                      <= 1'b0;
    penable                   <= 1'b0;
    pwrite                    <= 1'b0;
    paddr                     <= '0;
    pwdata                    <= '0;
    in_bus.valid              <= 1'b0;
    in_bus.sensor_outer_left  <= '0;
    in_bus.sensor_inner_left  <= '0;
    in_bus.sensor_inner_right <= '0;
    in_bus.sensor_outer_right <= '0;
    out_bus.ready             <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_config_extremes();
    test_random(125, 1'b1, 1'b1);
    test_random(125, 1'b0, 1'b0);
    test_backpressure();
    test_random(125, 1'b1, 1'b0);
    test_random(125, 1'b0, 1'b1);
    test_random(125, 1'b1, 1'b1);
    test_random(125, 1'b1, 1'b1);

    repeat (30) @(posedge clk);
    if (pending_duties.size() != 0)
      report_fail($sformatf("%0d results never arrived", pending_duties.size()));
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
